// File: hdl/ethernet_rx_frame_filter_macros.svh
// Assertion macros shared by the receive frame filter modules.
// Each macro expects signals named clock and reset in the using module.
`ifndef ETHERNET_RX_FRAME_FILTER_MACROS_SVH
`define ETHERNET_RX_FRAME_FILTER_MACROS_SVH

// Same-cycle implication, disabled during reset
`define RXFF_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset
`define RXFF_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hdl/rxff_pkg.sv
// Types and constants for the Ethernet receive frame filter.
// No dependencies; imported by rxff_hdr_track and ethernet_rx_frame_filter.
package rxff_pkg;

   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned COUNT_W = 16;
   localparam int unsigned MAC_W   = 48;
   localparam int unsigned ETYPE_W = 16;

   // Header layout
   localparam logic [COUNT_W-1:0] HDR_BYTES     = 16'd14;
   localparam logic [COUNT_W-1:0] MAC_BYTES     = 16'd6;
   localparam logic [COUNT_W-1:0] ETYPE_HI_POS  = 16'd12;
   localparam logic [COUNT_W-1:0] ETYPE_LO_POS  = 16'd13;
   localparam logic [BYTE_W-1:0]  BCAST_BYTE    = 8'hFF;

   localparam logic [ETYPE_W-1:0] ETYPE_ARP  = 16'h0806;
   localparam logic [ETYPE_W-1:0] ETYPE_IPV4 = 16'h0800;

   typedef enum logic [2:0] {
      VERDICT_ARP    = 3'd0,
      VERDICT_IPV4   = 3'd1,
      VERDICT_UNSUP  = 3'd2,
      VERDICT_NOT_US = 3'd3,
      VERDICT_SHORT  = 3'd4
   } verdict_type;

   typedef struct packed {
      logic [BYTE_W-1:0] frame_byte;
      logic              last_byte;
   } req_word_type;

   typedef struct packed {
      verdict_type        verdict;
      logic [ETYPE_W-1:0] ethertype;
      logic [COUNT_W-1:0] payload_length;
      logic               dest_is_broadcast;
      logic               dest_is_multicast;
   } rsp_word_type;

endpackage

// File: hdl/rxff_hdr_track.sv
// Per-frame header tracking (destination match, ethertype, byte count) and verdict logic.
// Depends on rxff_pkg and ethernet_rx_frame_filter_macros.svh.
`include "ethernet_rx_frame_filter_macros.svh"

module rxff_hdr_track
   import rxff_pkg::*;
#(
   parameter int MAX_FRAME_BYTES = 65535
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               step,
   input  req_word_type       word,
   input  logic [MAC_W-1:0]   own_mac,
   output rsp_word_type       result
);

   localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(MAX_FRAME_BYTES);

   logic [COUNT_W-1:0] count_ff, count_in;
   logic               own_match_ff, own_match_in;
   logic               all_ones_ff, all_ones_in;
   logic               group_ff, group_in;
   logic [ETYPE_W-1:0] type_ff, type_in;

   logic               in_mac;
   logic [BYTE_W-1:0]  mine;

   // Own MAC byte for the current destination position
   always_comb begin
      case (count_ff[2:0])
         3'd0:    mine = own_mac[47:40];
         3'd1:    mine = own_mac[39:32];
         3'd2:    mine = own_mac[31:24];
         3'd3:    mine = own_mac[23:16];
         3'd4:    mine = own_mac[15:8];
         3'd5:    mine = own_mac[7:0];
         default: mine = '0;
      endcase
   end

   // Updated frame state including the current word
   always_comb begin
      in_mac       = (count_ff < MAC_BYTES);
      own_match_in = own_match_ff & (~in_mac | (word.frame_byte == mine));
      all_ones_in  = all_ones_ff & (~in_mac | (word.frame_byte == BCAST_BYTE));
      group_in     = (count_ff == '0) ? word.frame_byte[0] : group_ff;
      type_in      = type_ff;
      if (count_ff == ETYPE_HI_POS) begin
         type_in[15:8] = word.frame_byte;
      end
      if (count_ff == ETYPE_LO_POS) begin
         type_in[7:0] = word.frame_byte;
      end
      count_in = (count_ff < MAX_COUNT) ? count_ff + 1'b1 : count_ff;
   end

   // Verdict from the updated state, used only on a last word
   always_comb begin
      result = '0;
      if (count_in < HDR_BYTES) begin
         result.verdict = VERDICT_SHORT;
      end else begin
         result.ethertype         = type_in;
         result.payload_length    = count_in - HDR_BYTES;
         result.dest_is_broadcast = all_ones_in;
         result.dest_is_multicast = group_in;
         if (!own_match_in && !all_ones_in && !group_in) begin
            result.verdict = VERDICT_NOT_US;
         end else if (type_in == ETYPE_ARP) begin
            result.verdict = VERDICT_ARP;
         end else if (type_in == ETYPE_IPV4) begin
            result.verdict = VERDICT_IPV4;
         end else begin
            result.verdict = VERDICT_UNSUP;
         end
      end
   end

   // Frame state: advance on each word, clear after the last one
   always_ff @(posedge clock) begin
      if (reset || (step && word.last_byte)) begin
         count_ff     <= '0;
         own_match_ff <= 1'b1;
         all_ones_ff  <= 1'b1;
         group_ff     <= 1'b0;
         type_ff      <= '0;
      end else if (step) begin
         count_ff     <= count_in;
         own_match_ff <= own_match_in;
         all_ones_ff  <= all_ones_in;
         group_ff     <= group_in;
         type_ff      <= type_in;
      end
   end

   `RXFF_ASSERT_NEXT(a_last_clears, step && word.last_byte, count_ff == '0 && own_match_ff,
      "frame state not cleared after last word")
   `RXFF_ASSERT_NEXT(a_count_steps, step && !word.last_byte && count_ff < MAX_COUNT,
      count_ff == $past(count_ff) + 1'b1, "byte count did not advance")
   `RXFF_ASSERT_NOW(a_count_cap, 1'b1, count_ff <= MAX_COUNT, "byte count above frame limit")

endmodule

// File: hdl/ethernet_rx_frame_filter.sv
// A word accepted into the input register is processed there; the verdict of a last word
// is registered into the output register and drives rsp. Throughput: one frame byte per
// clock; a last byte waits only while an untaken verdict is held in the output register.
// Reset: synchronous, active high; zeroes both valid flags and own MAC; resets frame state.
// Top level of the Ethernet II destination filter and ethertype classifier.
// Depends on rxff_pkg, rxff_hdr_track and ethernet_rx_frame_filter_macros.svh.
`include "ethernet_rx_frame_filter_macros.svh"

module ethernet_rx_frame_filter
   import rxff_pkg::*;
#(
   parameter int MAX_FRAME_BYTES = 65535
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  req_word_type     req_word,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rsp_word_type     rsp_word,
   input  logic             csr_we,
   input  logic [MAC_W-1:0] csr_wr_data
);

   logic             s1_valid_ff;
   req_word_type     s1_word_ff;
   logic             rsp_valid_ff;
   rsp_word_type     rsp_word_ff;
   logic [MAC_W-1:0] own_mac_ff;

   logic             out_free;
   logic             s1_step;
   rsp_word_type     verdict_word;

   // Stage handshake: a last word moves on only into a free output register
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign s1_step   = s1_valid_ff && (!s1_word_ff.last_byte || out_free);
   assign req_ready = !s1_valid_ff || s1_step;

   // Own MAC register
   always_ff @(posedge clock) begin
      if (reset) begin
         own_mac_ff <= '0;
      end else if (csr_we) begin
         own_mac_ff <= csr_wr_data;
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         s1_word_ff <= req_word;
      end
   end

   rxff_hdr_track #(
      .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
   ) u_hdr_track (
      .clock   (clock),
      .reset   (reset),
      .step    (s1_step),
      .word    (s1_word_ff),
      .own_mac (own_mac_ff),
      .result  (verdict_word)
   );

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_step && s1_word_ff.last_byte) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_step && s1_word_ff.last_byte) begin
         rsp_word_ff <= verdict_word;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   `RXFF_ASSERT_NOW(a_last_stalls, s1_valid_ff && s1_word_ff.last_byte && rsp_valid_ff && !rsp_ready,
      !req_ready && !s1_step, "last word advanced into a full output register")
   `RXFF_ASSERT_NEXT(a_verdict_from_last, s1_step && !s1_word_ff.last_byte && !out_free,
      rsp_valid_ff && $stable(rsp_word_ff), "held verdict disturbed by a middle word")
   `RXFF_ASSERT_NOW(a_short_zero, rsp_valid_ff && rsp_word_ff.verdict == VERDICT_SHORT,
      rsp_word_ff.ethertype == '0 && rsp_word_ff.payload_length == '0,
      "short frame verdict carries nonzero fields")

endmodule
